[design/imhq_pkg.sv]
`default_nettype none
package imhq_pkg;

    localparam int CAPACITY  = 256;
    localparam int POS_W     = 8;
    localparam int CNT_W     = 9;
    localparam int ID_W      = 8;
    localparam int NUM_IDS   = 256;
    localparam int KEY_W     = 32;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_DEL  = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_DUPLICATE = 3'd4;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [ID_W-1:0]  item_id;
        logic [KEY_W-1:0] priority_key;
    } req_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [ID_W-1:0]  removed_id;
        logic [KEY_W-1:0] removed_key;
        logic [CNT_W-1:0] entry_count;
        logic             min_valid;
        logic [ID_W-1:0]  min_id;
        logic [KEY_W-1:0] min_key;
    } rsp_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP_LAST,
        S_DEL_POS,
        S_DEL_ENT,
        S_DEL_LAST,
        S_DEL_PAR,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_OUT
    } state_t;

endpackage
`default_nettype wire

[design/indexed_min_heap_queue.sv]
`default_nettype none
// channel   dir  handshake            payload
// in        in   in_valid/in_stall    imhq_pkg::req_t
// out       out  out_valid/out_stall  imhq_pkg::rsp_t
// one request at a time; push climbs the heap level by level, pop descends it,
// delete moves the last entry into the gap and then climbs or descends; the reads of each level are
// serialised by the single read port of the heap memory
// reset clears count and the per-id held bits; memories need no clearing
// in_stall is high from acceptance until the response is taken
module indexed_min_heap_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire imhq_pkg::req_t  in_data,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output imhq_pkg::rsp_t       out_data
);
    import imhq_pkg::*;

    entry_t           heap_mem [CAPACITY];
    logic [POS_W-1:0] pos_mem  [NUM_IDS];

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg;
    logic [NUM_IDS-1:0] held_reg;
    entry_t           cur_reg, left_reg, min_reg;
    logic [POS_W-1:0] pos_reg;
    logic             rvalid_reg;
    logic [2:0]       status_reg;
    entry_t           rem_reg;
    entry_t           rd_data;
    logic [POS_W-1:0] ps_rd_data;

    logic             hp_re, hp_we, ps_re, ps_we;
    logic [POS_W-1:0] hp_raddr, hp_waddr, ps_wdata;
    logic [ID_W-1:0]  ps_raddr, ps_waddr;
    entry_t           hp_wdata;

    logic [POS_W-1:0] parent_pos, last_pos;
    logic [CNT_W:0]   left_pos, right_pos;
    logic             left_ok, right_ok, up_stop, best_left, best_right;
    logic [KEY_W-1:0] key_b;

    assign parent_pos = POS_W'((pos_reg - POS_W'(1)) >> 1);
    assign last_pos   = POS_W'(count_reg - CNT_W'(1));
    assign left_pos   = {1'b0, pos_reg, 1'b1};
    assign right_pos  = left_pos + (CNT_W+1)'(1);
    assign left_ok    = left_pos < {1'b0, count_reg};
    assign right_ok   = right_pos < {1'b0, count_reg};
    assign up_stop    = rd_data.key < cur_reg.key;
    assign best_left  = left_reg.key < cur_reg.key;
    assign key_b      = best_left ? left_reg.key : cur_reg.key;
    assign best_right = rvalid_reg && (rd_data.key < key_b);

    always_ff @(posedge clk)
    begin
        if (hp_we)
        begin
            heap_mem[hp_waddr] <= hp_wdata;
        end
        if (hp_re)
        begin
            rd_data <= heap_mem[hp_raddr];
        end
        if (ps_we)
        begin
            pos_mem[ps_waddr] <= ps_wdata;
        end
        if (ps_re)
        begin
            ps_rd_data <= pos_mem[ps_raddr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    priority case (1'b1)
                        in_data.opcode == OP_PUSH:
                        begin
                            if (count_reg == CNT_W'(CAPACITY) || held_reg[in_data.item_id])
                            begin
                                state_next = S_OUT;
                            end
                            else
                            begin
                                state_next = S_UP_RD;
                            end
                        end
                        in_data.opcode == OP_POP:
                        begin
                            if (count_reg <= CNT_W'(1))
                            begin
                                state_next = S_OUT;
                            end
                            else
                            begin
                                state_next = S_POP_LAST;
                            end
                        end
                        in_data.opcode == OP_DEL:
                        begin
                            if (count_reg == '0 || !held_reg[in_data.item_id])
                            begin
                                state_next = S_OUT;
                            end
                            else
                            begin
                                state_next = S_DEL_POS;
                            end
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_POP_LAST:
            begin
                state_next = S_DN_RDL;
            end
            S_DEL_POS:
            begin
                if (CNT_W'(ps_rd_data) >= count_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_DEL_ENT;
                end
            end
            S_DEL_ENT:
            begin
                if (pos_reg == last_pos)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_DEL_LAST;
                end
            end
            S_DEL_LAST:
            begin
                if (pos_reg != '0)
                begin
                    state_next = S_DEL_PAR;
                end
                else
                begin
                    state_next = S_DN_RDL;
                end
            end
            S_DEL_PAR:
            begin
                if (rd_data.key > cur_reg.key)
                begin
                    state_next = S_UP_CMP;
                end
                else
                begin
                    state_next = S_DN_RDL;
                end
            end
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (up_stop)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_UP_RD;
                end
            end
            S_DN_RDL:
            begin
                if (left_ok)
                begin
                    state_next = S_DN_RDR;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_DN_RDR:
            begin
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                if (best_left || best_right)
                begin
                    state_next = S_DN_RDL;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        hp_re    = 1'b0;
        hp_raddr = '0;
        hp_we    = 1'b0;
        hp_waddr = pos_reg;
        hp_wdata = cur_reg;
        ps_re    = 1'b0;
        ps_raddr = in_data.item_id;
        ps_we    = 1'b0;
        ps_waddr = cur_reg.id;
        ps_wdata = pos_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_data.opcode == OP_POP)
                begin
                    hp_re    = 1'b1;
                    hp_raddr = last_pos;
                end
                if (in_valid && in_data.opcode == OP_DEL)
                begin
                    ps_re = 1'b1;
                end
            end
            S_DEL_POS:
            begin
                hp_re    = 1'b1;
                hp_raddr = ps_rd_data;
            end
            S_DEL_ENT:
            begin
                hp_re    = 1'b1;
                hp_raddr = last_pos;
            end
            S_DEL_LAST:
            begin
                hp_re    = pos_reg != '0;
                hp_raddr = parent_pos;
            end
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    hp_we = 1'b1;
                    ps_we = 1'b1;
                end
                else
                begin
                    hp_re    = 1'b1;
                    hp_raddr = parent_pos;
                end
            end
            S_UP_CMP:
            begin
                hp_we = 1'b1;
                ps_we = 1'b1;
                if (!up_stop)
                begin
                    hp_wdata = rd_data;
                    ps_waddr = rd_data.id;
                end
            end
            S_DN_RDL:
            begin
                if (left_ok)
                begin
                    hp_re    = 1'b1;
                    hp_raddr = POS_W'(left_pos);
                end
                else
                begin
                    hp_we = 1'b1;
                    ps_we = 1'b1;
                end
            end
            S_DN_RDR:
            begin
                hp_re    = right_ok;
                hp_raddr = POS_W'(right_pos);
            end
            S_DN_CMP:
            begin
                hp_we = 1'b1;
                ps_we = 1'b1;
                if (best_right)
                begin
                    hp_wdata = rd_data;
                    ps_waddr = rd_data.id;
                end
                else if (best_left)
                begin
                    hp_wdata = left_reg;
                    ps_waddr = left_reg.id;
                end
            end
            default:
            begin
                hp_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            held_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE && in_valid)
            begin
                if (in_data.opcode == OP_PUSH && state_next == S_UP_RD)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                    held_reg[in_data.item_id] <= 1'b1;
                end
                if (in_data.opcode == OP_POP && count_reg != '0)
                begin
                    count_reg <= count_reg - CNT_W'(1);
                    held_reg[min_reg.id] <= 1'b0;
                end
            end
            if (state_reg == S_DEL_ENT)
            begin
                count_reg <= count_reg - CNT_W'(1);
                held_reg[cur_reg.id] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hp_we && hp_waddr == '0)
        begin
            min_reg <= hp_wdata;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                cur_reg.id  <= in_data.item_id;
                cur_reg.key <= in_data.priority_key;
                pos_reg     <= POS_W'(count_reg);
                rem_reg     <= '0;
                status_reg  <= ST_OK;
                if (in_data.opcode == OP_PUSH)
                begin
                    if (count_reg == CNT_W'(CAPACITY))
                    begin
                        status_reg <= ST_FULL;
                    end
                    else if (held_reg[in_data.item_id])
                    begin
                        status_reg <= ST_DUPLICATE;
                    end
                end
                else if (in_data.opcode == OP_POP)
                begin
                    if (count_reg == '0)
                    begin
                        status_reg <= ST_EMPTY;
                    end
                    else
                    begin
                        rem_reg <= min_reg;
                    end
                end
                else if (in_data.opcode == OP_DEL)
                begin
                    if (count_reg == '0)
                    begin
                        status_reg <= ST_EMPTY;
                    end
                    else if (!held_reg[in_data.item_id])
                    begin
                        status_reg <= ST_NOT_FOUND;
                    end
                end
            end
            S_POP_LAST:
            begin
                cur_reg <= rd_data;
                pos_reg <= '0;
            end
            S_DEL_POS:
            begin
                pos_reg <= ps_rd_data;
                if (CNT_W'(ps_rd_data) >= count_reg)
                begin
                    status_reg <= ST_NOT_FOUND;
                end
            end
            S_DEL_ENT:
            begin
                rem_reg <= rd_data;
            end
            S_DEL_LAST:
            begin
                cur_reg <= rd_data;
            end
            S_UP_CMP:
            begin
                if (!up_stop)
                begin
                    pos_reg <= parent_pos;
                end
            end
            S_DN_RDR:
            begin
                left_reg   <= rd_data;
                rvalid_reg <= right_ok;
            end
            S_DN_CMP:
            begin
                if (best_right)
                begin
                    pos_reg <= POS_W'(right_pos);
                end
                else if (best_left)
                begin
                    pos_reg <= POS_W'(left_pos);
                end
            end
            default:
            begin
                rvalid_reg <= rvalid_reg;
            end
        endcase
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = state_reg == S_OUT;

    always_comb
    begin
        out_data.status      = status_reg;
        out_data.removed_id  = rem_reg.id;
        out_data.removed_key = rem_reg.key;
        out_data.entry_count = count_reg;
        out_data.min_valid   = count_reg != '0;
        out_data.min_id      = (count_reg != '0) ? min_reg.id : '0;
        out_data.min_key     = (count_reg != '0) ? min_reg.key : '0;
    end

endmodule
`default_nettype wire
